### rtl/core/tle_pkg.sv
package tle_pkg;

   localparam int RING_DEPTH = 256;
   localparam int RING_AW    = $clog2(RING_DEPTH);
   localparam int RING_CW    = $clog2(RING_DEPTH + 1);
   localparam int LINE_DEPTH = 256;
   localparam int LINE_AW    = $clog2(LINE_DEPTH);
   localparam int CSR_AW     = 1;

   localparam logic [7:0] CH_INTR = 8'h03;
   localparam logic [7:0] CH_DEL  = 8'h7F;
   localparam logic [7:0] CH_CR   = 8'h0D;
   localparam logic [7:0] CH_LF   = 8'h0A;
   localparam logic [7:0] CH_BS   = 8'h08;
   localparam logic [7:0] CH_SP   = 8'h20;

   typedef enum logic [CSR_AW-1:0] {
      CSR_CANONICAL = 1'b0,
      CSR_ECHO      = 1'b1
   } csr_index_type;

   typedef enum logic {
      OP_RX   = 1'b0,
      OP_READ = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      KIND_ACCEPT = 3'd0,
      KIND_DROP   = 3'd1,
      KIND_ECHO   = 3'd2,
      KIND_DATA   = 3'd3,
      KIND_INTR   = 3'd4,
      KIND_EMPTY  = 3'd5
   } kind_type;

   // erase: the result opens the three-byte BS SP BS echo sequence
   typedef struct packed {
      kind_type   kind;
      logic [7:0] data;
      logic       last;
      logic       erase;
   } res_type;

   typedef struct packed {
      logic       push;
      logic [7:0] push_data;
      logic       pop;
   } ring_cmd_type;

   typedef struct packed {
      logic empty;
      logic full;
   } ring_state_type;

   typedef struct packed {
      logic               wr_en;
      logic [LINE_AW-1:0] wr_addr;
      logic [7:0]         wr_data;
      logic [LINE_AW-1:0] len;
      logic [LINE_AW-1:0] pos;
      logic               ready;
   } line_cmd_type;

   typedef struct packed {
      logic [LINE_AW-1:0] len;
      logic [LINE_AW-1:0] pos;
      logic               ready;
   } line_state_type;

   function automatic logic [RING_AW-1:0] ring_next(input logic [RING_AW-1:0] idx);
      if (idx == RING_AW'(RING_DEPTH - 1)) begin
         return '0;
      end
      return idx + RING_AW'(1);
   endfunction

endpackage

### rtl/core/tle_ring.sv
module tle_ring (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    update,
   input  tle_pkg::ring_cmd_type   cmd,
   input  logic                    capture,
   output tle_pkg::ring_state_type state,
   output logic [7:0]              rd_data
);
   import tle_pkg::*;

   logic [7:0]         mem [RING_DEPTH];
   logic [RING_AW-1:0] head_ff, head_in;
   logic [RING_AW-1:0] tail_ff, tail_in;
   logic [RING_CW-1:0] count_ff, count_in;
   logic [7:0]         rd_data_ff;
   logic               push_en, pop_en;

   assign push_en = update && cmd.push;
   assign pop_en  = update && cmd.pop;

   always_comb begin
      head_in  = push_en ? ring_next(head_ff) : head_ff;
      tail_in  = pop_en ? ring_next(tail_ff) : tail_ff;
      count_in = count_ff;
      if (push_en && !pop_en) begin
         count_in = count_ff + RING_CW'(1);
      end else if (pop_en && !push_en) begin
         count_in = count_ff - RING_CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   // prefetch the oldest byte for the transaction being taken in;
   // bypass the write landing on the same entry
   always_ff @(posedge clock) begin
      if (push_en) begin
         mem[head_ff] <= cmd.push_data;
      end
      if (capture) begin
         if (push_en && head_ff == tail_in) begin
            rd_data_ff <= cmd.push_data;
         end else begin
            rd_data_ff <= mem[tail_in];
         end
      end
   end

   assign state.empty = (count_ff == '0);
   assign state.full  = (count_ff == RING_CW'(RING_DEPTH));
   assign rd_data     = rd_data_ff;

endmodule

### rtl/core/tle_line.sv
module tle_line (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    update,
   input  tle_pkg::line_cmd_type   cmd,
   input  logic                    capture,
   output tle_pkg::line_state_type state,
   output logic [7:0]              rd_data
);
   import tle_pkg::*;

   logic [7:0]         mem [LINE_DEPTH];
   logic [LINE_AW-1:0] len_ff;
   logic [LINE_AW-1:0] pos_ff, pos_in;
   logic               ready_ff;
   logic [7:0]         rd_data_ff;
   logic               wr_en;

   assign wr_en  = update && cmd.wr_en;
   assign pos_in = update ? cmd.pos : pos_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff   <= '0;
         pos_ff   <= '0;
         ready_ff <= 1'b0;
      end else if (update) begin
         len_ff   <= cmd.len;
         pos_ff   <= cmd.pos;
         ready_ff <= cmd.ready;
      end
   end

   // prefetch the next byte to deliver
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[cmd.wr_addr] <= cmd.wr_data;
      end
      if (capture) begin
         if (wr_en && cmd.wr_addr == pos_in) begin
            rd_data_ff <= cmd.wr_data;
         end else begin
            rd_data_ff <= mem[pos_in];
         end
      end
   end

   assign state.len   = len_ff;
   assign state.pos   = pos_ff;
   assign state.ready = ready_ff;
   assign rd_data     = rd_data_ff;

endmodule

### rtl/core/tle_step.sv
module tle_step (
   input  logic                    op,
   input  logic [7:0]              rx_byte,
   input  logic                    canonical_mode,
   input  logic                    echo_enable,
   input  tle_pkg::ring_state_type ring_state,
   input  logic [7:0]              ring_data,
   input  tle_pkg::line_state_type line_state,
   input  logic [7:0]              line_data,
   output tle_pkg::ring_cmd_type   ring_cmd,
   output tle_pkg::line_cmd_type   line_cmd,
   output tle_pkg::res_type        res
);
   import tle_pkg::*;

   logic [7:0]         rx_char;
   logic [7:0]         pop_char;
   logic [LINE_AW-1:0] eff_len;
   logic               room;
   logic               delivering;
   logic               line_done;

   assign rx_char  = (rx_byte == CH_CR) ? CH_LF : rx_byte;
   assign pop_char = (ring_data == CH_CR) ? CH_LF : ring_data;

   assign delivering = line_state.ready && (line_state.pos < line_state.len);
   assign line_done  = ({1'b0, line_state.pos} + (LINE_AW + 1)'(1)) >= {1'b0, line_state.len};
   // a stale ready flag with nothing to deliver drops the line
   assign eff_len    = line_state.ready ? '0 : line_state.len;
   assign room       = (eff_len != LINE_AW'(LINE_DEPTH - 1));

   always_comb begin
      ring_cmd.push      = 1'b0;
      ring_cmd.push_data = rx_char;
      ring_cmd.pop       = 1'b0;
      line_cmd.wr_en     = 1'b0;
      line_cmd.wr_addr   = eff_len;
      line_cmd.wr_data   = pop_char;
      line_cmd.len       = eff_len;
      line_cmd.pos       = line_state.ready ? '0 : line_state.pos;
      line_cmd.ready     = 1'b0;
      res.kind           = KIND_ACCEPT;
      res.data           = '0;
      res.last           = 1'b1;
      res.erase          = 1'b0;

      if (op == OP_RX) begin
         line_cmd.len   = line_state.len;
         line_cmd.pos   = line_state.pos;
         line_cmd.ready = line_state.ready;
         if (ring_state.full) begin
            res.kind = KIND_DROP;
         end else begin
            ring_cmd.push = 1'b1;
         end
      end else if (delivering) begin
         res.kind = KIND_DATA;
         res.data = line_data;
         if (line_done) begin
            line_cmd.len = '0;
            line_cmd.pos = '0;
         end else begin
            line_cmd.len   = line_state.len;
            line_cmd.pos   = line_state.pos + LINE_AW'(1);
            line_cmd.ready = 1'b1;
            res.last       = 1'b0;
         end
      end else if (ring_state.empty) begin
         res.kind = KIND_EMPTY;
      end else begin
         ring_cmd.pop = 1'b1;
         if (pop_char == CH_INTR) begin
            line_cmd.len = '0;
            line_cmd.pos = '0;
            res.kind     = KIND_INTR;
         end else if (!canonical_mode) begin
            res.kind = KIND_DATA;
            res.data = ring_data;
         end else if (pop_char == CH_LF) begin
            line_cmd.wr_en = room;
            line_cmd.len   = room ? eff_len + LINE_AW'(1) : eff_len;
            line_cmd.pos   = '0;
            line_cmd.ready = 1'b1;
            if (echo_enable) begin
               res.kind = KIND_ECHO;
               res.data = CH_LF;
            end
         end else if (pop_char == CH_BS || pop_char == CH_DEL) begin
            if (eff_len != '0) begin
               line_cmd.len = eff_len - LINE_AW'(1);
               if (echo_enable) begin
                  res.kind  = KIND_ECHO;
                  res.data  = CH_BS;
                  res.last  = 1'b0;
                  res.erase = 1'b1;
               end
            end
         end else if (room) begin
            line_cmd.wr_en = 1'b1;
            line_cmd.len   = eff_len + LINE_AW'(1);
            if (echo_enable) begin
               res.kind = KIND_ECHO;
               res.data = pop_char;
            end
         end
      end
   end

endmodule

### rtl/core/tle_out.sv
module tle_out (
   input  logic             clock,
   input  logic             reset,
   input  logic             load,
   input  tle_pkg::res_type res,
   output logic             can_load,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [7:0]       rsp_tdata,   // data
   output logic [2:0]       rsp_tuser,   // kind
   output logic             rsp_tlast    // last
);
   import tle_pkg::*;

   logic       valid_ff;
   logic [1:0] remain_ff;
   kind_type   kind_ff;
   logic [7:0] data_ff;
   logic       last_ff;
   logic       take;

   assign take     = valid_ff && rsp_tready;
   assign can_load = !valid_ff || (take && remain_ff == 2'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         remain_ff <= 2'd0;
      end else if (load) begin
         valid_ff  <= 1'b1;
         remain_ff <= res.erase ? 2'd2 : 2'd0;
      end else if (take) begin
         if (remain_ff == 2'd0) begin
            valid_ff <= 1'b0;
         end else begin
            remain_ff <= remain_ff - 2'd1;
         end
      end
   end

   // step through SP then BS after the leading BS of an erase
   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff <= res.kind;
         data_ff <= res.data;
         last_ff <= res.last;
      end else if (take && remain_ff == 2'd2) begin
         data_ff <= CH_SP;
      end else if (take && remain_ff == 2'd1) begin
         data_ff <= CH_BS;
         last_ff <= 1'b1;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = kind_ff;
   assign rsp_tlast  = last_ff;

endmodule

### rtl/core/tty_line_editor_top.sv
// Console line discipline.
// req channel: tuser selects the transaction (0 = byte received from the line,
// 1 = reader step), tdata carries the received byte. A received byte is queued
// in a receive ring (CR becomes LF) or dropped when the ring is full. A reader
// step hands out the next byte of a finished line, reports an empty ring, or
// pops one byte and edits the current line with it (erase, echo, newline,
// Ctrl-C interrupt); in raw mode any popped byte but Ctrl-C goes straight out.
// rsp channel: tuser is the result kind, tdata the echo or data byte, tlast
// marks the final result of a transaction and, for line data, the line end.
// Each transaction gives one result, except an echoed erase which gives three.
// A transaction waits in the input register, where the ring and line
// memories return the entry it needs, and its first result is then loaded
// into the result register. One transaction per cycle is taken while rsp
// keeps up; an erase echo holds the pipe until its SP and BS are taken.
// When rsp stalls the result register holds and the input register fills,
// then req_tready drops. Reset empties the ring and the line and restores
// canonical mode with echo on; the memories themselves are not cleared.
// csr port: index 0 canonical mode, index 1 echo enable, bit 0 of the data.
module tty_line_editor_top (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [7:0]                 req_tdata,   // rx_byte
   input  logic                       req_tuser,   // op
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [7:0]                 rsp_tdata,   // data
   output logic [2:0]                 rsp_tuser,   // kind
   output logic                       rsp_tlast,   // last
   input  logic                       csr_wr_en,
   input  logic [tle_pkg::CSR_AW-1:0] csr_index,
   input  logic [0:0]                 csr_wdata
);
   import tle_pkg::*;

   logic           canonical_ff;
   logic           echo_ff;
   logic           stage_valid_ff;
   logic           stage_op_ff;
   logic [7:0]     stage_byte_ff;
   logic           capture;
   logic           fire;
   logic           can_load;
   ring_cmd_type   ring_cmd;
   ring_state_type ring_state;
   logic [7:0]     ring_data;
   line_cmd_type   line_cmd;
   line_state_type line_state;
   logic [7:0]     line_data;
   res_type        res;

   always_ff @(posedge clock) begin
      if (reset) begin
         canonical_ff <= 1'b1;
         echo_ff      <= 1'b1;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_CANONICAL: canonical_ff <= csr_wdata[0];
            CSR_ECHO:      echo_ff      <= csr_wdata[0];
            default:       ;
         endcase
      end
   end

   assign fire       = stage_valid_ff && can_load;
   assign req_tready = !stage_valid_ff || fire;
   assign capture    = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else if (req_tready) begin
         stage_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (capture) begin
         stage_op_ff   <= req_tuser;
         stage_byte_ff <= req_tdata;
      end
   end

   tle_ring u_ring (
      .clock   (clock),
      .reset   (reset),
      .update  (fire),
      .cmd     (ring_cmd),
      .capture (capture),
      .state   (ring_state),
      .rd_data (ring_data)
   );

   tle_line u_line (
      .clock   (clock),
      .reset   (reset),
      .update  (fire),
      .cmd     (line_cmd),
      .capture (capture),
      .state   (line_state),
      .rd_data (line_data)
   );

   tle_step u_step (
      .op             (stage_op_ff),
      .rx_byte        (stage_byte_ff),
      .canonical_mode (canonical_ff),
      .echo_enable    (echo_ff),
      .ring_state     (ring_state),
      .ring_data      (ring_data),
      .line_state     (line_state),
      .line_data      (line_data),
      .ring_cmd       (ring_cmd),
      .line_cmd       (line_cmd),
      .res            (res)
   );

   tle_out u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (fire),
      .res        (res),
      .can_load   (can_load),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
